// ===== hdl/sha_pkg.sv =====
// sha_pkg: shared types and codes for the slot handle allocator
// command and response transaction structs, operation and status codes
// no dependencies
`default_nettype none

package sha_pkg;

  localparam int OpW     = 3;
  localparam int SlotW   = 10;
  localparam int HandleW = 64;
  localparam int StatW   = 2;
  localparam int TotalW  = 32;

  typedef enum logic [OpW-1:0] {
    OP_ADD     = 3'd0,
    OP_FREE    = 3'd1,
    OP_GET     = 3'd2,
    OP_REPLACE = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  // one command transaction
  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [SlotW-1:0]   slot_id;
    logic [HandleW-1:0] handle;
    logic               handle_is_null;
    logic               already_has_id;
  } cmd_t;

  // one response transaction
  typedef struct packed {
    logic [StatW-1:0]   status;
    logic [SlotW-1:0]   slot_out;
    logic [HandleW-1:0] handle_out;
    logic               handle_out_present;
    logic [TotalW-1:0]  allocated_total;
    logic [TotalW-1:0]  freed_total;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/slot_handle_allocator_top.sv =====
// slot_handle_allocator_top: slot table mapping ids to handles with a lifo free-id stack
// holds the slot table memory, the free stack memory and the single pass op logic
// depends on sha_pkg
`default_nettype none

// Usage
//   command channel: a transaction is taken at a rising edge with start high and
//   busy low. busy is always low, so one command can be issued every cycle.
//   response channel: done is high for exactly one cycle with rsp valid; the
//   receiver must take it then, it cannot stall the block.
//   a command taken is registered into stage 1 with the memory read data, and
//   its response is registered into done and rsp. throughput: one command per
//   cycle, set by the one read port and one write port of the slot table and
//   free stack memories; the memory reads happen at the accept edge and the
//   previous command's writes are forwarded around them.
//   slot validity is qualified by the high-water count, so neither memory
//   needs a clearing pass: reset and the clear command take effect at once.
//   reset (rst, synchronous) empties the table, the stack and both counters;
//   any command in flight is dropped.
module slot_handle_allocator_top #(
  parameter int CAPACITY     = 1024,
  parameter int HANDLE_WIDTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire sha_pkg::cmd_t cmd,
  output logic               done,
  output sha_pkg::rsp_t      rsp
);

  localparam int IdW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int TblW = HANDLE_WIDTH + 1;

  // memories: entry = {valid, handle}
  logic [TblW-1:0] tbl_mem [CAPACITY];
  logic [IdW-1:0]  stk_mem [CAPACITY];

  // state
  logic [CntW-1:0]            high_water, high_water_next;
  logic [CntW-1:0]            free_count, free_count_next;
  logic [sha_pkg::TotalW-1:0] alloc_counter, alloc_counter_next;
  logic [sha_pkg::TotalW-1:0] free_counter, free_counter_next;

  // stage 1: registered command and memory read data
  logic            s1_valid;
  sha_pkg::cmd_t   s1_cmd;
  logic [TblW-1:0] tbl_q;
  logic [IdW-1:0]  stk_q;
  logic [IdW-1:0]  stk_raddr, stk_raddr_next;

  // write ports and their registered forwarding copies
  logic            tbl_we, tbl_fw_we;
  logic [IdW-1:0]  tbl_wa, tbl_fw_addr;
  logic [TblW-1:0] tbl_wd, tbl_fw_data;
  logic            stk_we, stk_fw_we;
  logic [IdW-1:0]  stk_wa, stk_fw_addr;
  logic [IdW-1:0]  stk_wd, stk_fw_data;

  // stage 2 combinational values
  logic [IdW-1:0]          sid_idx;
  logic                    in_range;
  logic [TblW-1:0]         tbl_rd;
  logic [IdW-1:0]          stk_top;
  logic [HANDLE_WIDTH-1:0] h_in;
  sha_pkg::rsp_t           rsp_next;

  assign busy = 1'b0;

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_cmd    <= cmd;
    stk_raddr <= stk_raddr_next;
  end

  // slot table memory
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_q <= tbl_mem[IdW'(cmd.slot_id)];
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q <= stk_mem[stk_raddr_next];
  end

  // forwarding copies of the writes done at the read edge
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_fw_we <= 1'b0;
      stk_fw_we <= 1'b0;
    end else begin
      tbl_fw_we <= tbl_we;
      stk_fw_we <= stk_we;
    end
    tbl_fw_addr <= tbl_wa;
    tbl_fw_data <= tbl_wd;
    stk_fw_addr <= stk_wa;
    stk_fw_data <= stk_wd;
  end

  // top of stack for the next command, from the updated fill count
  assign stk_raddr_next = IdW'(free_count_next - CntW'(1));

  // read data with forwarding
  assign sid_idx  = IdW'(s1_cmd.slot_id);
  assign in_range = 32'(s1_cmd.slot_id) < 32'(high_water);
  assign tbl_rd   = (tbl_fw_we && tbl_fw_addr == sid_idx) ? tbl_fw_data : tbl_q;
  assign stk_top  = (stk_fw_we && stk_fw_addr == stk_raddr) ? stk_fw_data : stk_q;
  assign h_in     = s1_cmd.handle[HANDLE_WIDTH-1:0];

  // operation logic
  always_comb begin
    high_water_next    = high_water;
    free_count_next    = free_count;
    alloc_counter_next = alloc_counter;
    free_counter_next  = free_counter;
    tbl_we = 1'b0;
    tbl_wa = sid_idx;
    tbl_wd = {1'b1, h_in};
    stk_we = 1'b0;
    stk_wa = IdW'(free_count);
    stk_wd = sid_idx;
    rsp_next.status             = sha_pkg::ST_OK;
    rsp_next.slot_out           = s1_cmd.slot_id;
    rsp_next.handle_out         = '0;
    rsp_next.handle_out_present = 1'b0;
    if (s1_valid) begin
      case (s1_cmd.op)
        sha_pkg::OP_ADD: begin
          if (free_count != '0) begin
            // reuse a freed id
            free_count_next   = free_count - CntW'(1);
            tbl_we            = 1'b1;
            tbl_wa            = stk_top;
            rsp_next.slot_out = sha_pkg::SlotW'(stk_top);
          end else if (s1_cmd.already_has_id) begin
            rsp_next.status = sha_pkg::ST_IGNORED;
          end else if (32'(high_water) >= CAPACITY) begin
            rsp_next.status = sha_pkg::ST_FULL;
          end else begin
            // fresh id
            tbl_we             = 1'b1;
            tbl_wa             = IdW'(high_water);
            high_water_next    = high_water + CntW'(1);
            alloc_counter_next = alloc_counter + sha_pkg::TotalW'(1);
            rsp_next.slot_out  = sha_pkg::SlotW'(high_water);
          end
        end
        sha_pkg::OP_FREE: begin
          if (in_range && tbl_rd[HANDLE_WIDTH]) begin
            tbl_we            = 1'b1;
            tbl_wd            = '0;
            free_counter_next = free_counter + sha_pkg::TotalW'(1);
            if (32'(free_count) < CAPACITY) begin
              stk_we          = 1'b1;
              free_count_next = free_count + CntW'(1);
            end
          end else begin
            rsp_next.status = sha_pkg::ST_BAD;
          end
        end
        sha_pkg::OP_GET: begin
          if (in_range && tbl_rd[HANDLE_WIDTH]) begin
            rsp_next.handle_out         = sha_pkg::HandleW'(tbl_rd[HANDLE_WIDTH-1:0]);
            rsp_next.handle_out_present = 1'b1;
          end else begin
            rsp_next.status = sha_pkg::ST_BAD;
          end
        end
        sha_pkg::OP_REPLACE: begin
          if (in_range) begin
            if (tbl_rd[HANDLE_WIDTH]) begin
              rsp_next.handle_out         = sha_pkg::HandleW'(tbl_rd[HANDLE_WIDTH-1:0]);
              rsp_next.handle_out_present = 1'b1;
            end
            tbl_we = 1'b1;
            tbl_wd = s1_cmd.handle_is_null ? '0 : {1'b1, h_in};
          end else begin
            rsp_next.status = sha_pkg::ST_BAD;
          end
        end
        sha_pkg::OP_CLEAR: begin
          high_water_next    = '0;
          free_count_next    = '0;
          alloc_counter_next = '0;
          free_counter_next  = '0;
        end
        default: begin
          rsp_next.status = sha_pkg::ST_IGNORED;
        end
      endcase
    end
    rsp_next.allocated_total = alloc_counter_next;
    rsp_next.freed_total     = free_counter_next;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      high_water    <= '0;
      free_count    <= '0;
      alloc_counter <= '0;
      free_counter  <= '0;
    end else begin
      high_water    <= high_water_next;
      free_count    <= free_count_next;
      alloc_counter <= alloc_counter_next;
      free_counter  <= free_counter_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    rsp <= rsp_next;
  end

endmodule

`default_nettype wire

// ===== hdl/sha_checker.sv =====
// sha_checker: port-level checks for the slot handle allocator
// bound to slot_handle_allocator_top; depends on sha_pkg
`default_nettype none

module sha_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire sha_pkg::cmd_t cmd,
  input wire logic          done,
  input wire sha_pkg::rsp_t rsp
);

  // every accepted command is answered with done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted command gave no response");

  // no response without a command
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("response without a command");

  // clear reports ok and zeroed counters
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cmd.op, 2) == sha_pkg::OP_CLEAR) |->
      (rsp.status == sha_pkg::ST_OK && rsp.allocated_total == '0 && rsp.freed_total == '0))
    else $error("clear response wrong");

  // unknown opcodes are ignored
  a_unknown_op: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cmd.op, 2) > sha_pkg::OP_CLEAR) |-> rsp.status == sha_pkg::ST_IGNORED)
    else $error("unknown op not ignored");

  // an absent handle reads as zero
  a_null_handle: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.handle_out_present) |-> rsp.handle_out == '0)
    else $error("handle_out nonzero without a handle");

endmodule

bind slot_handle_allocator_top sha_checker u_sha_checker (.*);

`default_nettype wire
